[src/cqr_pkg.sv]
// Shared opcodes, status codes and controller/datapath interface types for the queue.
package cqr_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_READOUT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       ins;         // write value at tail, advance tail
    logic       del;         // read head, advance head
    logic       load;        // read head, start readout pointer after it
    logic       step;        // read at readout pointer, advance it
    logic       rep;         // emit an immediate result
    logic [1:0] rep_status;
    logic       rd_last;     // the read issued now yields the final result
  } cqr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic occ_one;
    logic cnt_one;
  } cqr_stat_t;

endpackage

[src/circular_queue_with_readout_top.sv]
// Insert and full/empty reports give their result in the cycle after acceptance.
// Delete passes its read through the memory read register and then the output registers;
// busy is high for a single cycle. Readout of N entries takes the same path, one result
// per cycle, set by the single registered memory read port; busy stays high until the
// last result reaches the outputs. Inserts sustain one per cycle. Results cannot be stalled
// by the receiver. Synchronous rst empties the queue; stored words are not cleared.
module circular_queue_with_readout_top #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic               last
);
  import cqr_pkg::*;

  cqr_cmd_t  cmd;
  cqr_stat_t stat;

  cqr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  cqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .value  (value),
    .strobe (strobe),
    .status (status),
    .data   (data),
    .last   (last)
  );

endmodule

[src/cqr_ctrl.sv]
// Controller state machine: decodes each transaction and sequences readout reads.
module cqr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  cqr_pkg::cqr_stat_t stat,
  output cqr_pkg::cqr_cmd_t  cmd,
  output logic              busy
);
  import cqr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rep_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_INSERT: begin
              cmd.rep = 1'b1;
              if (stat.full) cmd.rep_status = ST_FULL;
              else           cmd.ins        = 1'b1;
            end
            OP_DELETE: begin
              if (stat.empty) begin
                cmd.rep        = 1'b1;
                cmd.rep_status = ST_EMPTY;
              end else begin
                cmd.del     = 1'b1;
                cmd.rd_last = 1'b1;
                state_next  = S_DRAIN;
              end
            end
            OP_READOUT: begin
              if (stat.empty) begin
                cmd.rep        = 1'b1;
                cmd.rep_status = ST_EMPTY;
              end else begin
                cmd.load    = 1'b1;
                cmd.rd_last = stat.occ_one;
                state_next  = stat.occ_one ? S_DRAIN : S_RUN;
              end
            end
            default: ; // unused opcode: drop the transaction
          endcase
        end
      end
      S_RUN: begin
        cmd.step    = 1'b1;
        cmd.rd_last = stat.cnt_one;
        if (stat.cnt_one) state_next = S_DRAIN;
      end
      // hold off new work while the last read result moves to the outputs
      S_DRAIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

`ifndef SYNTH
  a_step_only_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (state == S_RUN))
    else $error("readout step outside run state");

  a_drain_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_IDLE))
    else $error("drain state did not return to idle");

  a_run_has_entries: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !cmd.rd_last) |=> (state == S_RUN) && !stat.empty)
    else $error("readout run entered without entries");
`endif

endmodule

[src/cqr_dp.sv]
// Datapath: entry memory, head/tail pointers, occupancy, readout counter and result registers.
module cqr_dp #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cqr_pkg::cqr_cmd_t   cmd,
  output cqr_pkg::cqr_stat_t  stat,
  input  logic signed [31:0]  value,
  output logic                strobe,
  output logic [1:0]          status,
  output logic signed [31:0]  data,
  output logic                last
);
  import cqr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] head, tail, ptr, rd_addr;
  logic [CW-1:0] occ, cnt;
  logic          pend_valid, pend_last;
  logic          rd_en;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == AW'(DEPTH - 1)) r = '0;
    else                     r = i + AW'(1);
    return r;
  endfunction

  assign rd_en   = cmd.del | cmd.load | cmd.step;
  assign rd_addr = cmd.step ? ptr : head;

  assign stat.full    = (occ == CW'(DEPTH));
  assign stat.empty   = (occ == '0);
  assign stat.occ_one = (occ == CW'(1));
  assign stat.cnt_one = (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.ins) mem[tail] <= value;
    if (rd_en)   rd_data   <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      ptr        <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      if (cmd.ins) begin
        tail <= wrap_inc(tail);
        occ  <= occ + CW'(1);
      end
      if (cmd.del) begin
        head <= wrap_inc(head);
        occ  <= occ - CW'(1);
      end
      // readout walks a private pointer; the queue itself is left alone
      if (cmd.load) begin
        ptr <= wrap_inc(head);
        cnt <= occ - CW'(1);
      end else if (cmd.step) begin
        ptr <= wrap_inc(ptr);
        cnt <= cnt - CW'(1);
      end
      pend_valid <= rd_en;
      pend_last  <= cmd.rd_last;
      strobe     <= cmd.rep | pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      status <= ST_OK;
      data   <= rd_data;
      last   <= pend_last;
    end else begin
      status <= cmd.rep_status;
      data   <= '0;
      last   <= 1'b1;
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_no_result_collision: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rep && pend_valid))
    else $error("immediate result collides with pending read");

  a_delete_yields_last: assert property (@(posedge clk) disable iff (rst)
    cmd.del |=> pend_valid && pend_last)
    else $error("delete did not produce a final read result");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> (occ == $past(occ) + CW'(1)))
    else $error("insert did not grow occupancy by one");
`endif

endmodule
